// ----- rtl/core/lsec_pkg.sv -----
// shared types, constants and tables for the led strip effect controller
// no dependencies; used by led_strip_effect_controller_core

package lsec_pkg;

    localparam int PIXEL_COUNT = 60;
    localparam int PIX_W       = 6;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RAINBOW_INTERVAL = 1'b0,
        CFG_PREVIEW_DURATION = 1'b1
    } cfg_index_t;

    localparam logic [15:0] RAINBOW_INTERVAL_RESET = 16'd50;
    localparam logic [15:0] PREVIEW_DURATION_RESET = 16'd500;

    // command word ranges
    localparam logic [31:0] CMD_BRIGHT_LO = 32'd2000;
    localparam logic [31:0] CMD_BRIGHT_HI = 32'd2255;
    localparam logic [31:0] CMD_MODE_LO   = 32'd10;
    localparam logic [31:0] CMD_MODE_HI   = 32'd20;
    localparam logic [31:0] CMD_COLOUR_LO = 32'd50;
    localparam logic [31:0] CMD_COLOUR_HI = 32'd69;
    localparam logic [31:0] CMD_OFF       = 32'd99;
    localparam logic [31:0] CMD_COUNT_LO  = 32'd100;
    localparam logic [31:0] CMD_COUNT_HI  = 32'd160;

    // modes
    localparam logic [7:0] MODE_RAINBOW = 8'd10;
    localparam logic [7:0] MODE_SOLID   = 8'd20;
    localparam logic [7:0] MODE_OFF     = 8'd99;

    localparam logic [7:0] BRIGHT_RESET = 8'd255;

    localparam int          OFFSET_W    = 11;
    localparam logic [10:0] OFFSET_WRAP = 11'(256 * 5);

    localparam int          PALETTE_SIZE = 20;
    localparam logic [4:0]  PALETTE_LAST = 5'(PALETTE_SIZE - 1);

    typedef enum logic [1:0] {
        FRAME_PREVIEW,
        FRAME_RAINBOW,
        FRAME_SOLID,
        FRAME_BLACK
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef logic [7:0] base_table_t [2**PIX_W];

    // start position on the wheel for each pixel
    function automatic base_table_t make_base_table();
        base_table_t t;
        for (int i = 0; i < 2**PIX_W; i++) begin
            t[i] = 8'((i * 256) / PIXEL_COUNT);
        end
        return t;
    endfunction

    localparam base_table_t BASE_TABLE = make_base_table();

    function automatic rgb_t palette(input logic [4:0] sel);
        rgb_t c;
        unique case (sel)
            5'd0:    c = '{8'd255, 8'd0,   8'd0};
            5'd1:    c = '{8'd0,   8'd255, 8'd0};
            5'd2:    c = '{8'd0,   8'd0,   8'd255};
            5'd3:    c = '{8'd0,   8'd255, 8'd255};
            5'd4:    c = '{8'd255, 8'd0,   8'd255};
            5'd5:    c = '{8'd255, 8'd255, 8'd0};
            5'd6:    c = '{8'd255, 8'd255, 8'd255};
            5'd7:    c = '{8'd255, 8'd105, 8'd180};
            5'd8:    c = '{8'd250, 8'd128, 8'd114};
            5'd9:    c = '{8'd255, 8'd165, 8'd0};
            5'd10:   c = '{8'd255, 8'd215, 8'd0};
            5'd11:   c = '{8'd165, 8'd42,  8'd42};
            5'd12:   c = '{8'd0,   8'd128, 8'd128};
            5'd13:   c = '{8'd191, 8'd255, 8'd0};
            5'd14:   c = '{8'd75,  8'd0,   8'd130};
            5'd15:   c = '{8'd238, 8'd130, 8'd238};
            5'd16:   c = '{8'd0,   8'd0,   8'd128};
            5'd17:   c = '{8'd192, 8'd192, 8'd192};
            5'd18:   c = '{8'd128, 8'd128, 8'd128};
            default: c = '{8'd0,   8'd0,   8'd0};
        endcase
        return c;
    endfunction

    // colour wheel: red to green to blue and back
    function automatic rgb_t wheel(input logic [7:0] pos);
        rgb_t       c;
        logic [7:0] p;
        logic [7:0] q;
        p = 8'd255 - pos;
        if (p < 8'd85) begin
            q = 8'(p * 3);
            c = '{8'd255 - q, 8'd0, q};
        end else if (p < 8'd170) begin
            q = 8'((p - 8'd85) * 3);
            c = '{8'd0, q, 8'd255 - q};
        end else begin
            q = 8'((p - 8'd170) * 3);
            c = '{q, 8'd255 - q, 8'd0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/led_strip_effect_controller_core.sv -----
// led strip effect controller: command decode, effect state and pixel stream
// depends on lsec_pkg
//
// usage: the in channel takes words of action, command_word and now_ms. a command
// word (action 0) updates brightness, mode, palette colour or the lit-pixel count.
// a render tick (action 1) may start a frame of PIXEL_COUNT pixel words on the out
// channel, one per cycle while out is ready, the last one flagged by frame_end. a
// frame carries the brightness, colour and rainbow offset as they stood when its
// tick was taken. the cfg channel writes the rainbow interval and preview duration
// and is always ready; the user must write it only while the block is idle, which
// the block does not enforce. a word goes into the input register and is decoded
// there; a tick starts the stepper, which loads each pixel into the output register.
// throughput: commands pass at one a cycle, also while a frame is streaming, unless
// a tick waits ahead of them; a tick holds the pixel stepper for the whole frame, so
// frames go out back to back, one pixel a cycle while out is ready; a following
// tick waits in the input register. a stall on out holds the current pixel word and
// freezes the stepper; a tick then fills the input register and in_ready falls.
// reset: brightness 255, mode off, palette red, no preview pending, both time
// marks zero, rainbow interval 50 ms and preview duration 500 ms.

module led_strip_effect_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [31:0]                         command_word,
    input  logic [31:0]                         now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lsec_pkg::PIX_W-1:0]          pixel_index,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic [7:0]                          level,
    output logic                                frame_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam logic [lsec_pkg::PIX_W-1:0] LAST_PIX =
        lsec_pkg::PIX_W'(lsec_pkg::PIXEL_COUNT - 1);

    // configuration
    logic [15:0] interval_reg;
    logic [15:0] duration_reg;

    // input register
    logic        hold_valid_reg;
    logic        action_reg;
    logic [31:0] word_reg;
    logic [31:0] now_reg;

    // effect state
    logic [7:0]                      brightness_reg;
    logic [7:0]                      mode_reg;
    logic [4:0]                      colour_sel_reg;
    logic [lsec_pkg::PIX_W-1:0]      lit_count_reg;
    logic                            pending_reg;
    logic [31:0]                     preview_start_reg;
    logic [31:0]                     rainbow_last_reg;
    logic [lsec_pkg::OFFSET_W-1:0]   offset_reg;

    // pixel stepper
    logic                            frame_active_reg;
    logic [lsec_pkg::PIX_W-1:0]      pix_reg;
    lsec_pkg::frame_kind_t           kind_reg;
    lsec_pkg::rgb_t                  colour_reg;
    logic [lsec_pkg::PIX_W-1:0]      lit_reg;
    logic [7:0]                      level_reg;
    logic [7:0]                      frame_offset_reg;

    // output register
    logic                            out_valid_reg;
    logic [lsec_pkg::PIX_W-1:0]      pixel_index_reg;
    lsec_pkg::rgb_t                  pixel_rgb_reg;
    logic [7:0]                      level_out_reg;
    logic                            frame_end_reg;

    logic                            load;
    logic                            last_load;
    logic                            stepper_free;
    logic                            consume;
    logic                            is_cmd;
    logic                            is_tick;
    logic [31:0]                     eff_start;
    logic                            in_preview;
    logic                            too_soon;
    logic                            start_frame;
    lsec_pkg::frame_kind_t           start_kind;
    lsec_pkg::rgb_t                  sel_colour;
    lsec_pkg::rgb_t                  pixel_rgb;
    logic [lsec_pkg::OFFSET_W-1:0]   offset_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= lsec_pkg::RAINBOW_INTERVAL_RESET;
            duration_reg <= lsec_pkg::PREVIEW_DURATION_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (lsec_pkg::cfg_index_t'(cfg_index))
                lsec_pkg::CFG_RAINBOW_INTERVAL: interval_reg <= cfg_data;
                lsec_pkg::CFG_PREVIEW_DURATION: duration_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshakes and decode
    assign load         = frame_active_reg && (!out_valid_reg || out_ready);
    assign last_load    = load && (pix_reg == LAST_PIX);
    assign stepper_free = !frame_active_reg || last_load;
    assign is_cmd       = hold_valid_reg && !action_reg;
    assign is_tick      = hold_valid_reg && action_reg;
    assign consume      = is_cmd || (is_tick && stepper_free);
    assign in_ready     = !hold_valid_reg || consume;

    assign sel_colour = lsec_pkg::palette((colour_sel_reg < lsec_pkg::PALETTE_SIZE[4:0])
                                          ? colour_sel_reg : lsec_pkg::PALETTE_LAST);

    assign eff_start  = pending_reg ? now_reg : preview_start_reg;
    assign in_preview = (now_reg - eff_start) < {16'd0, duration_reg};
    assign too_soon   = (now_reg - rainbow_last_reg) < {16'd0, interval_reg};

    always_comb
    begin
        start_kind  = lsec_pkg::FRAME_BLACK;
        start_frame = 1'b0;
        priority if (in_preview)
        begin
            start_kind  = lsec_pkg::FRAME_PREVIEW;
            start_frame = 1'b1;
        end
        else if (mode_reg == lsec_pkg::MODE_RAINBOW)
        begin
            start_kind  = lsec_pkg::FRAME_RAINBOW;
            start_frame = !too_soon;
        end
        else if (mode_reg == lsec_pkg::MODE_SOLID)
        begin
            start_kind  = lsec_pkg::FRAME_SOLID;
            start_frame = 1'b1;
        end
        else if (mode_reg == lsec_pkg::MODE_OFF)
        begin
            start_kind  = lsec_pkg::FRAME_BLACK;
            start_frame = 1'b1;
        end
        else
        begin
            start_kind  = lsec_pkg::FRAME_BLACK;
            start_frame = 1'b0;
        end
    end

    assign offset_next = (offset_reg + 1'b1 >= lsec_pkg::OFFSET_WRAP)
                         ? '0 : offset_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg <= action;
            word_reg   <= command_word;
            now_reg    <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg    <= lsec_pkg::BRIGHT_RESET;
            mode_reg          <= lsec_pkg::MODE_OFF;
            colour_sel_reg    <= '0;
            lit_count_reg     <= '0;
            pending_reg       <= 1'b0;
            preview_start_reg <= '0;
            rainbow_last_reg  <= '0;
            offset_reg        <= '0;
        end
        else if (consume && is_cmd)
        begin
            if (word_reg >= lsec_pkg::CMD_BRIGHT_LO && word_reg <= lsec_pkg::CMD_BRIGHT_HI)
                brightness_reg <= 8'(word_reg - lsec_pkg::CMD_BRIGHT_LO);
            if ((word_reg >= lsec_pkg::CMD_MODE_LO && word_reg <= lsec_pkg::CMD_MODE_HI)
                || word_reg == lsec_pkg::CMD_OFF)
                mode_reg <= word_reg[7:0];
            if (word_reg >= lsec_pkg::CMD_COLOUR_LO && word_reg <= lsec_pkg::CMD_COLOUR_HI)
                colour_sel_reg <= 5'(word_reg - lsec_pkg::CMD_COLOUR_LO);
            if (word_reg >= lsec_pkg::CMD_COUNT_LO && word_reg <= lsec_pkg::CMD_COUNT_HI)
            begin
                lit_count_reg <= lsec_pkg::PIX_W'(word_reg - lsec_pkg::CMD_COUNT_LO);
                pending_reg   <= 1'b1;
            end
        end
        else if (consume && is_tick)
        begin
            pending_reg       <= 1'b0;
            preview_start_reg <= eff_start;
            if (start_frame && start_kind == lsec_pkg::FRAME_RAINBOW)
            begin
                rainbow_last_reg <= now_reg;
                offset_reg       <= offset_next;
            end
        end
    end

    // pixel stepper
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            pix_reg          <= '0;
        end
        else if (consume && is_tick && start_frame)
        begin
            frame_active_reg <= 1'b1;
            pix_reg          <= '0;
        end
        else if (load)
        begin
            frame_active_reg <= !last_load;
            pix_reg          <= last_load ? '0 : pix_reg + 1'b1;
        end
    end

    // frame snapshot so later commands leave this frame alone
    always_ff @(posedge clk)
    begin
        if (consume && is_tick && start_frame)
        begin
            kind_reg         <= start_kind;
            colour_reg       <= sel_colour;
            lit_reg          <= lit_count_reg;
            level_reg        <= brightness_reg;
            frame_offset_reg <= offset_reg[7:0];
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            lsec_pkg::FRAME_PREVIEW:
                pixel_rgb = (pix_reg < lit_reg) ? colour_reg : '0;
            lsec_pkg::FRAME_RAINBOW:
                pixel_rgb = lsec_pkg::wheel(lsec_pkg::BASE_TABLE[pix_reg] + frame_offset_reg);
            lsec_pkg::FRAME_SOLID:
                pixel_rgb = colour_reg;
            default:
                pixel_rgb = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_index_reg <= pix_reg;
            pixel_rgb_reg   <= pixel_rgb;
            level_out_reg   <= level_reg;
            frame_end_reg   <= (pix_reg == LAST_PIX);
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red         = pixel_rgb_reg.r;
    assign green       = pixel_rgb_reg.g;
    assign blue        = pixel_rgb_reg.b;
    assign level       = level_out_reg;
    assign frame_end   = frame_end_reg;

    // checks
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> pixel_index_reg == LAST_PIX)
        else $error("frame_end on a pixel other than the last");

    a_pix_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_active_reg |-> pix_reg <= LAST_PIX)
        else $error("pixel stepper beyond the strip");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        consume && is_tick && frame_active_reg |-> last_load)
        else $error("tick taken while a frame is still streaming");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg < lsec_pkg::OFFSET_WRAP)
        else $error("rainbow offset beyond its wrap");

    a_load_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        consume && is_tick && start_frame |=> frame_active_reg && pix_reg == '0)
        else $error("frame did not start at the first pixel");

endmodule

// ----- sim/tb_top.sv -----
// self-checking bench for led_strip_effect_controller_core: drives command words and
// render ticks, predicts every pixel word and compares the out stream against it
// depends on lsec_pkg and the core rtl

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_COMMAND   = 1'b0;
    localparam logic ACT_TICK      = 1'b1;
    localparam int   NPIX          = lsec_pkg::PIXEL_COUNT;
    localparam int   SETTLE_CYCLES = 10;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   RANDOM_ITEMS  = 400;
    localparam int   RANDOM_PHASES = 5;

    typedef struct packed {
        logic [lsec_pkg::PIX_W-1:0] idx;
        logic [7:0]                 r;
        logic [7:0]                 g;
        logic [7:0]                 b;
        logic [7:0]                 lvl;
        logic                       last;
    } pixel_word_t;

    typedef enum {FR_NONE, FR_PREVIEW, FR_RAINBOW, FR_SOLID, FR_BLACK} frame_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic                             action;
    logic [31:0]                      command_word;
    logic [31:0]                      now_ms;
    logic                             out_valid;
    logic                             out_ready;
    logic [lsec_pkg::PIX_W-1:0]       pixel_index;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic [7:0]                       level;
    logic                             frame_end;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lsec_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]                      cfg_data;

    // predicted strip state
    logic [15:0] rb_interval;
    logic [15:0] pv_duration;
    logic [7:0]  bright;
    logic [7:0]  mode;
    logic [4:0]  colour_sel;
    logic [5:0]  lit_count;
    logic [31:0] pv_start;
    logic [31:0] rb_last;
    logic [10:0] rb_offset;
    bit          pv_pending;

    logic [23:0] colour_table [20] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF, 24'hFF00FF,
        24'hFFFF00, 24'hFFFFFF, 24'hFF69B4, 24'hFA8072, 24'hFFA500,
        24'hFFD700, 24'hA52A2A, 24'h008080, 24'hBFFF00, 24'h4B0082,
        24'hEE82EE, 24'h000080, 24'hC0C0C0, 24'h808080, 24'h000000
    };

    pixel_word_t expected_pixels [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b1;
    int          hold_req       = 0;
    int          hold_left      = 0;
    int          pat_kind       = 0;
    int          pat_left       = 0;
    int          pat_phase      = 0;
    logic [31:0] clock_ms;

    led_strip_effect_controller_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .command_word (command_word),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_index  (pixel_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .level        (level),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        int p;
        p = 255 - int'(pos);
        if (p < 85)
        begin
            return {8'(255 - 3 * p), 8'd0, 8'(3 * p)};
        end
        else if (p < 170)
        begin
            p = p - 85;
            return {8'd0, 8'(3 * p), 8'(255 - 3 * p)};
        end
        p = p - 170;
        return {8'(3 * p), 8'(255 - 3 * p), 8'd0};
    endfunction

    function automatic void reset_strip_model();
        rb_interval = lsec_pkg::RAINBOW_INTERVAL_RESET;
        pv_duration = lsec_pkg::PREVIEW_DURATION_RESET;
        bright      = 8'd255;
        mode        = lsec_pkg::MODE_OFF;
        colour_sel  = 5'd0;
        lit_count   = 6'd0;
        pv_start    = 32'd0;
        rb_last     = 32'd0;
        rb_offset   = 11'd0;
        pv_pending  = 1'b0;
    endfunction

    // update the predicted state for one accepted word and queue the frame it causes
    function automatic void predict_strip(input logic act, input logic [31:0] word,
                                          input logic [31:0] t);
        logic [23:0] c;
        logic [23:0] pix_rgb;
        logic [31:0] dt;
        pixel_word_t px;
        frame_t      kind;
        if (act == ACT_COMMAND)
        begin
            if (word >= lsec_pkg::CMD_BRIGHT_LO && word <= lsec_pkg::CMD_BRIGHT_HI)
                bright = 8'(word - lsec_pkg::CMD_BRIGHT_LO);
            if (word >= lsec_pkg::CMD_MODE_LO && word <= lsec_pkg::CMD_MODE_HI)
                mode = word[7:0];
            if (word >= lsec_pkg::CMD_COLOUR_LO && word <= lsec_pkg::CMD_COLOUR_HI)
                colour_sel = 5'(word - lsec_pkg::CMD_COLOUR_LO);
            if (word == lsec_pkg::CMD_OFF)
                mode = lsec_pkg::MODE_OFF;
            if (word >= lsec_pkg::CMD_COUNT_LO && word <= lsec_pkg::CMD_COUNT_HI)
            begin
                lit_count  = 6'(word - lsec_pkg::CMD_COUNT_LO);
                pv_pending = 1'b1;
            end
            return;
        end
        c = colour_table[colour_sel];
        if (pv_pending)
        begin
            pv_start   = t;
            pv_pending = 1'b0;
        end
        kind = FR_NONE;
        dt   = t - pv_start;
        if (dt < {16'd0, pv_duration})
            kind = FR_PREVIEW;
        else if (mode == lsec_pkg::MODE_RAINBOW)
        begin
            dt = t - rb_last;
            if (dt >= {16'd0, rb_interval})
                kind = FR_RAINBOW;
        end
        else if (mode == lsec_pkg::MODE_SOLID)
            kind = FR_SOLID;
        else if (mode == lsec_pkg::MODE_OFF)
            kind = FR_BLACK;
        if (kind == FR_NONE)
            return;
        for (int i = 0; i < NPIX; i++)
        begin
            case (kind)
                FR_PREVIEW: pix_rgb = (i < int'(lit_count)) ? c : 24'd0;
                FR_RAINBOW: pix_rgb = wheel_rgb(8'((i * 256) / NPIX + int'(rb_offset)));
                FR_SOLID:   pix_rgb = c;
                default:    pix_rgb = 24'd0;
            endcase
            px.idx  = lsec_pkg::PIX_W'(i);
            px.r    = pix_rgb[23:16];
            px.g    = pix_rgb[15:8];
            px.b    = pix_rgb[7:0];
            px.lvl  = bright;
            px.last = (i == NPIX - 1);
            expected_pixels.push_back(px);
        end
        if (kind == FR_RAINBOW)
        begin
            rb_last   = t;
            rb_offset = (rb_offset + 11'd1 >= 11'(256 * 5)) ? 11'd0 : rb_offset + 11'd1;
        end
    endfunction

    function automatic void note_mismatch(input string what, input pixel_word_t want,
                                          input bit have_want);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            if (have_want)
                $display({"%s: expected idx %0d rgb %02h%02h%02h level %0d end %0b,",
                          " got idx %0d rgb %02h%02h%02h level %0d end %0b"},
                         what, want.idx, want.r, want.g, want.b, want.lvl, want.last,
                         pixel_index, red, green, blue, level, frame_end);
            else
                $display("%s: got idx %0d rgb %02h%02h%02h level %0d end %0b",
                         what, pixel_index, red, green, blue, level, frame_end);
        end
    endfunction

    // pixel word checker
    always @(posedge clk)
    begin
        pixel_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected pixel word", want, 1'b0);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_index !== want.idx || red !== want.r || green !== want.g ||
                    blue !== want.b || level !== want.lvl || frame_end !== want.last)
                    note_mismatch("pixel word mismatch", want, 1'b1);
            end
        end
    end

    // receiver: a long hold on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_kind = $urandom_range(0, 3);
                    pat_left = $urandom_range(20, 200);
                end
                pat_left--;
                pat_phase++;
                case (pat_kind)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ((pat_phase % 5) < 3);
                    default: out_ready <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run timed out after %0d cycles, %0d pixel words outstanding",
                     cycle_count, expected_pixels.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [31:0] word, input logic [31:0] t);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            if (!gaps_on)
                burst_left = 1000;
            else if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(1, 10);
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        action       <= act;
        command_word <= word;
        now_ms       <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_strip(act, word, t);
    endtask

    task automatic send_command(input logic [31:0] word);
        send_word(ACT_COMMAND, word, $urandom());
    endtask

    task automatic send_tick(input logic [31:0] t);
        send_word(ACT_TICK, $urandom(), t);
    endtask

    // drop valid and wait for every predicted pixel word, then idle for the settle time given by extra
    task automatic wait_quiet(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input lsec_pkg::cfg_index_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            lsec_pkg::CFG_RAINBOW_INTERVAL: rb_interval = data;
            lsec_pkg::CFG_PREVIEW_DURATION: pv_duration = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_after_reset();
        // zero lit pixels in a preview window that opens at time zero
        send_tick(32'd0);
        send_tick(32'd499);
        send_tick(32'd500);
    endtask

    task automatic test_commands();
        send_command(lsec_pkg::CMD_BRIGHT_LO);
        send_command(lsec_pkg::CMD_MODE_HI);
        send_command(lsec_pkg::CMD_COLOUR_LO + 32'd7);
        send_tick(32'd1000);
        // words outside all ranges, some just outside one, change nothing
        send_command(lsec_pkg::CMD_BRIGHT_HI + 32'd1);
        send_command(lsec_pkg::CMD_COUNT_HI + 32'd1);
        send_command(lsec_pkg::CMD_OFF - 32'd1);
        send_command(32'hFFFF_FFFF);
        send_command(32'd0);
        send_command(lsec_pkg::CMD_BRIGHT_HI);
        send_command(lsec_pkg::CMD_COLOUR_HI);
        send_tick(32'd1100);
    endtask

    task automatic test_rainbow();
        send_command(32'(lsec_pkg::MODE_RAINBOW));
        send_tick(32'd2000);
        send_tick(32'd2049);
        send_tick(32'd2050);
        send_command(lsec_pkg::CMD_MODE_LO + 32'd1);
        send_tick(32'd2100);
    endtask

    task automatic test_preview();
        // last count before the tick wins, and the window spans the time wrap
        send_command(lsec_pkg::CMD_COUNT_HI);
        send_command(lsec_pkg::CMD_COLOUR_LO + 32'd8);
        send_command(lsec_pkg::CMD_COUNT_LO + 32'd30);
        send_tick(32'hFFFF_FF00);
        send_tick(32'h0000_0010);
        send_command(lsec_pkg::CMD_OFF);
        send_tick(32'h0000_0300);
    endtask

    task automatic test_output_hold();
        wait_quiet(SETTLE_CYCLES);
        gaps_on    = 1'b0;
        burst_left = 0;
        hold_req   = 300;
        send_command(32'(lsec_pkg::MODE_SOLID));
        for (int i = 0; i < 8; i++)
            send_tick(32'd5000 + 32'(i));
        wait_quiet(0);
        gaps_on    = 1'b1;
        burst_left = 0;
    endtask

    task automatic send_random_word();
        int          pick;
        logic [31:0] word;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 19) == 0)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + 32'($urandom_range(0, 150));
            send_tick(clock_ms);
            return;
        end
        if (pick < 57)
        begin
            case ($urandom_range(0, 3))
                0:       word = 32'(lsec_pkg::MODE_RAINBOW);
                1:       word = 32'(lsec_pkg::MODE_SOLID);
                2:       word = lsec_pkg::CMD_OFF;
                default: word = 32'($urandom_range(lsec_pkg::CMD_MODE_LO,
                                                   lsec_pkg::CMD_MODE_HI));
            endcase
        end
        else if (pick < 67)
            word = 32'($urandom_range(lsec_pkg::CMD_COLOUR_LO, lsec_pkg::CMD_COLOUR_HI));
        else if (pick < 75)
            word = 32'($urandom_range(lsec_pkg::CMD_BRIGHT_LO, lsec_pkg::CMD_BRIGHT_HI));
        else if (pick < 83)
            word = 32'($urandom_range(lsec_pkg::CMD_COUNT_LO, lsec_pkg::CMD_COUNT_HI));
        else if (pick < 92)
            word = $urandom();
        else
        begin
            case ($urandom_range(0, 4))
                0:       word = lsec_pkg::CMD_MODE_LO - 32'd1;
                1:       word = lsec_pkg::CMD_COLOUR_HI + 32'd1;
                2:       word = lsec_pkg::CMD_COUNT_LO - 32'd2;
                3:       word = lsec_pkg::CMD_BRIGHT_LO - 32'd1;
                default: word = lsec_pkg::CMD_BRIGHT_HI + 32'd1;
            endcase
        end
        send_command(word);
    endtask

    task automatic test_random_traffic();
        logic [15:0] interval;
        logic [15:0] duration;
        clock_ms = 32'd8000;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    interval = 16'd0;
                    duration = 16'd0;
                end
                1:
                begin
                    interval = 16'hFFFF;
                    duration = 16'hFFFF;
                end
                2:
                begin
                    interval = 16'($urandom());
                    duration = 16'($urandom());
                end
                3:
                begin
                    interval = 16'($urandom_range(0, 200));
                    duration = 16'($urandom_range(0, 1500));
                end
                default:
                begin
                    interval = lsec_pkg::RAINBOW_INTERVAL_RESET;
                    duration = lsec_pkg::PREVIEW_DURATION_RESET;
                end
            endcase
            wait_quiet(SETTLE_CYCLES);
            write_register(lsec_pkg::CFG_RAINBOW_INTERVAL, interval);
            write_register(lsec_pkg::CFG_PREVIEW_DURATION, duration);
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
            begin
                send_random_word();
                // now and then let the strip drain completely
                if ($urandom_range(0, 49) == 0)
                    wait_quiet(0);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_COMMAND;
        command_word = 32'd0;
        now_ms       = 32'd0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = lsec_pkg::CFG_RAINBOW_INTERVAL;
        cfg_data     = 16'd0;
        reset_strip_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_commands();
        test_rainbow();
        test_preview();
        test_output_hold();
        test_random_traffic();

        wait_quiet(20);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lsec_pkg.sv
rtl/core/led_strip_effect_controller_core.sv
sim/tb_top.sv
